>>> src/rk4s_pkg.sv
`timescale 1ns / 1ps

package rk4s_pkg;

  localparam int QW        = 64;
  localparam int FRAC      = 32;
  localparam int HW        = 32;
  localparam int DT_W      = 63;
  localparam int STO_W     = 24;
  localparam int NIB_W     = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic [DT_W-1:0]       dt_t;
  typedef logic [STO_W-1:0]      sto_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    q_t   infection_coef;
    q_t   recovery_rate;
    q_t   inflow_rate;
    dt_t  step_size;
    sto_t stoich_packed;
  } cfg_t;

  typedef struct packed {
    logic start;
    q_t   op_a;
    q_t   op_b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    q_t   product;
    logic sat;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic by_six;
    q_t   dividend;
  } div_req_t;

  typedef struct packed {
    logic done;
    q_t   quotient;
  } div_rsp_t;

endpackage

>>> src/rk4s_in_if.sv
`timescale 1ns / 1ps

interface rk4s_in_if;
  logic          valid;
  logic          ready;
  logic          load_initial;
  rk4s_pkg::q_t  initial_s;
  rk4s_pkg::q_t  initial_i;
  rk4s_pkg::q_t  time_value;

  modport source (
    output valid, load_initial, initial_s, initial_i, time_value,
    input  ready
  );
  modport sink (
    input  valid, load_initial, initial_s, initial_i, time_value,
    output ready
  );
endinterface

>>> src/rk4s_out_if.sv
`timescale 1ns / 1ps

interface rk4s_out_if;
  logic          valid;
  logic          ready;
  rk4s_pkg::q_t  time_out;
  rk4s_pkg::q_t  s_out;
  rk4s_pkg::q_t  i_out;
  logic          saturated;

  modport source (
    output valid, time_out, s_out, i_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, time_out, s_out, i_out, saturated,
    output ready
  );
endinterface

>>> src/rk4s_cfg_if.sv
`timescale 1ns / 1ps

interface rk4s_cfg_if;
  logic                valid;
  logic                ready;
  rk4s_pkg::cfg_idx_t  reg_index;
  logic [63:0]         wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );
  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

>>> src/rk4s_qmul.sv
`timescale 1ns / 1ps

module rk4s_qmul (
  input  logic               clk,
  input  logic               rst_n,
  input  rk4s_pkg::mul_req_t req,
  output rk4s_pkg::mul_rsp_t rsp
);

  localparam int QW   = rk4s_pkg::QW;
  localparam int HW   = rk4s_pkg::HW;
  localparam int FRAC = rk4s_pkg::FRAC;
  localparam int AW   = 2 * QW;

  localparam logic [2:0] ST_FIX_A = 3'd5;
  localparam logic [2:0] ST_FIX_B = 3'd6;
  localparam logic [2:0] ST_LAST  = 3'd7;

  logic          busy_r;
  logic [2:0]    step_r;
  logic [QW-1:0] a_r;
  logic [QW-1:0] b_r;
  logic [QW-1:0] pp_r;
  logic [QW-1:0] pp_nxt;
  logic [1:0]    off_r;
  logic [1:0]    off_nxt;
  logic [AW-1:0] acc_r;
  logic [AW-1:0] acc_nxt;
  logic [AW-1:0] addend;
  logic [HW-1:0] fx;
  logic [HW-1:0] fy;
  logic [QW-1:0] hi;
  logic [QW-1:0] lo;
  logic          ovf;

  always_comb begin
    fx      = step_r[1] ? a_r[QW-1:HW] : a_r[HW-1:0];
    fy      = step_r[0] ? b_r[QW-1:HW] : b_r[HW-1:0];
    pp_nxt  = fx * fy;
    off_nxt = 2'(step_r[0]) + 2'(step_r[1]);
    hi      = acc_r[AW-1:QW];
    lo      = acc_r[QW-1:0];

    unique case (off_r)
      2'd0:    addend = AW'(pp_r);
      2'd1:    addend = AW'(pp_r) << HW;
      default: addend = AW'(pp_r) << QW;
    endcase

    acc_nxt = acc_r;
    unique case (step_r)
      3'd1, 3'd2, 3'd3, 3'd4: acc_nxt = acc_r + addend;
      ST_FIX_A: if (a_r[QW-1]) acc_nxt[AW-1:QW] = hi - b_r;
      ST_FIX_B: if (b_r[QW-1]) acc_nxt[AW-1:QW] = hi - a_r;
      default: acc_nxt = acc_r;
    endcase

    ovf = (|hi[QW-1:FRAC-1]) && !(&hi[QW-1:FRAC-1]);
  end

  assign rsp.done    = busy_r && (step_r == ST_LAST);
  assign rsp.sat     = ovf;
  assign rsp.product = ovf ? (hi[QW-1] ? rk4s_pkg::Q_MIN : rk4s_pkg::Q_MAX)
                           : {hi[FRAC-1:0], lo[QW-1:FRAC]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      if (step_r == ST_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r  <= pp_nxt;
    off_r <= off_nxt;
    if (req.start) begin
      a_r   <= req.op_a;
      b_r   <= req.op_b;
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> src/rk4s_div3.sv
`timescale 1ns / 1ps

module rk4s_div3 (
  input  logic               clk,
  input  logic               rst_n,
  input  rk4s_pkg::div_req_t req,
  output rk4s_pkg::div_rsp_t rsp
);

  localparam int QW     = rk4s_pkg::QW;
  localparam int DIGITS = 4;
  localparam int ITER   = QW / DIGITS;
  localparam int CNT_W  = $clog2(ITER);
  localparam logic [2:0] DIVISOR = 3'd3;

  logic             busy_r;
  logic             fin_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             six_r;
  logic [QW-1:0]    mag_r;
  logic [QW-1:0]    mag_nxt;
  logic [1:0]       rem_r;
  logic [1:0]       rem_nxt;
  logic [2:0]       trial;
  logic             qbit;
  logic [QW-1:0]    qmag;

  always_comb begin
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    trial   = '0;
    qbit    = 1'b0;
    for (int j = 0; j < DIGITS; j++) begin
      trial   = {rem_nxt, mag_nxt[QW-1]};
      qbit    = (trial >= DIVISOR);
      rem_nxt = qbit ? 2'(trial - DIVISOR) : trial[1:0];
      mag_nxt = {mag_nxt[QW-2:0], qbit};
    end
    qmag = six_r ? (mag_r >> 1) : mag_r;
  end

  assign rsp.done     = fin_r;
  assign rsp.quotient = neg_r ? -qmag : qmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(ITER - 1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else begin
      fin_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mag_r <= req.dividend[QW-1] ? -req.dividend : req.dividend;
      rem_r <= '0;
      neg_r <= req.dividend[QW-1];
      six_r <= req.by_six;
    end else if (busy_r) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> src/rk4s_seq.sv
`timescale 1ns / 1ps

module rk4s_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  rk4s_pkg::cfg_t     cfg,
  rk4s_in_if.sink            in_ch,
  rk4s_out_if.source         out_ch,
  output rk4s_pkg::mul_req_t mul_req,
  input  rk4s_pkg::mul_rsp_t mul_rsp,
  output rk4s_pkg::div_req_t div_req,
  input  rk4s_pkg::div_rsp_t div_rsp
);

  localparam int QW    = rk4s_pkg::QW;
  localparam int FRAC  = rk4s_pkg::FRAC;
  localparam int NIB_W = rk4s_pkg::NIB_W;
  localparam int DT_W  = rk4s_pkg::DT_W;

  localparam logic [1:0] STAGE_FIRST   = 2'd0;
  localparam logic [1:0] STAGE_FULL_DT = 2'd2;
  localparam logic [1:0] STAGE_LAST    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    OP_SI     = 4'd0,
    OP_H0     = 4'd1,
    OP_H1     = 4'd2,
    OP_ST_0S  = 4'd3,
    OP_ST_0I  = 4'd4,
    OP_ST_1S  = 4'd5,
    OP_ST_1I  = 4'd6,
    OP_ST_2S  = 4'd7,
    OP_ST_2I  = 4'd8,
    OP_DIV_S  = 4'd9,
    OP_DIV_I  = 4'd10,
    OP_Y_S    = 4'd11,
    OP_Y_I    = 4'd12,
    OP_X_S    = 4'd13,
    OP_X_I    = 4'd14
  } op_t;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [1:0]       stage_r, stage_nxt;
  logic             sat_r, sat_nxt;
  logic             out_valid_r, out_valid_nxt;

  rk4s_pkg::q_t     xs_r, xi_r;
  rk4s_pkg::q_t     ys_r, yi_r;
  rk4s_pkg::q_t     t_r, h0_r, h1_r;
  rk4s_pkg::q_t     d0_r, d1_r;
  rk4s_pkg::q_t     sum_s_r, sum_i_r;
  rk4s_pkg::q_t     time_r;
  rk4s_pkg::q_t     out_time_r, out_s_r, out_i_r;
  logic             out_sat_r;

  logic             accept;
  logic             is_div;
  logic             uses_add;
  logic             unit_done;
  logic             wb;
  logic             out_load;
  logic [2:0]       sto_j;
  logic [NIB_W-1:0] sto_nib;
  rk4s_pkg::q_t     sto_q;
  rk4s_pkg::q_t     h_sel;
  rk4s_pkg::q_t     half_q;
  rk4s_pkg::q_t     dt_q;
  rk4s_pkg::q_t     step_mul;
  rk4s_pkg::q_t     mul_a, mul_b;
  rk4s_pkg::q_t     add_a, add_b, add_sum, add_res;
  logic             add_ovf;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    is_div    = (op_r == OP_DIV_S) || (op_r == OP_DIV_I);
    unit_done = is_div ? div_rsp.done : mul_rsp.done;
    wb        = (state_r == ST_WAIT) && unit_done;
    sto_j     = 3'(op_r - OP_ST_0S);
    sto_nib   = cfg.stoich_packed[NIB_W*sto_j +: NIB_W];
    sto_q     = {{(QW-FRAC-NIB_W){sto_nib[NIB_W-1]}}, sto_nib, {FRAC{1'b0}}};
    half_q    = {2'b00, cfg.step_size[DT_W-1:1]};
    dt_q      = {1'b0, cfg.step_size};
    step_mul  = (stage_r == STAGE_FULL_DT) ? dt_q : half_q;

    unique case (sto_j[2:1])
      2'd0:    h_sel = h0_r;
      2'd1:    h_sel = h1_r;
      default: h_sel = cfg.inflow_rate;
    endcase

    mul_a    = '0;
    mul_b    = '0;
    add_a    = '0;
    uses_add = 1'b1;
    unique case (op_r)
      OP_SI: begin
        mul_a    = cfg.infection_coef;
        mul_b    = ys_r;
        uses_add = 1'b0;
      end
      OP_H0: begin
        mul_a    = t_r;
        mul_b    = yi_r;
        uses_add = 1'b0;
      end
      OP_H1: begin
        mul_a    = cfg.recovery_rate;
        mul_b    = yi_r;
        uses_add = 1'b0;
      end
      OP_ST_0S, OP_ST_0I, OP_ST_1S, OP_ST_1I, OP_ST_2S, OP_ST_2I: begin
        mul_a = sto_q;
        mul_b = h_sel;
        add_a = sto_j[0] ? d1_r : d0_r;
      end
      OP_DIV_S: add_a = sum_s_r;
      OP_DIV_I: add_a = sum_i_r;
      OP_Y_S: begin
        mul_a = d0_r;
        mul_b = step_mul;
        add_a = xs_r;
      end
      OP_Y_I: begin
        mul_a = d1_r;
        mul_b = step_mul;
        add_a = xi_r;
      end
      OP_X_S: begin
        mul_a = sum_s_r;
        mul_b = dt_q;
        add_a = xs_r;
      end
      OP_X_I: begin
        mul_a = sum_i_r;
        mul_b = dt_q;
        add_a = xi_r;
      end
      default: uses_add = 1'b0;
    endcase

    add_b   = is_div ? div_rsp.quotient : mul_rsp.product;
    add_sum = add_a + add_b;
    add_ovf = (add_a[QW-1] == add_b[QW-1]) && (add_sum[QW-1] != add_a[QW-1]);
    add_res = add_ovf ? (add_a[QW-1] ? rk4s_pkg::Q_MIN : rk4s_pkg::Q_MAX) : add_sum;
  end

  assign mul_req.start    = (state_r == ST_ISSUE) && !is_div;
  assign mul_req.op_a     = mul_a;
  assign mul_req.op_b     = mul_b;
  assign div_req.start    = (state_r == ST_ISSUE) && is_div;
  assign div_req.by_six   = (stage_r == STAGE_FIRST) || (stage_r == STAGE_LAST);
  assign div_req.dividend = (op_r == OP_DIV_I) ? d1_r : d0_r;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.time_out  = out_time_r;
  assign out_ch.s_out     = out_s_r;
  assign out_ch.i_out     = out_i_r;
  assign out_ch.saturated = out_sat_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    stage_nxt     = stage_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sat_nxt   = 1'b0;
          op_nxt    = OP_SI;
          stage_nxt = STAGE_FIRST;
          state_nxt = in_ch.load_initial ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (unit_done) begin
          sat_nxt = sat_r | (!is_div && mul_rsp.sat) | (uses_add && add_ovf);
          if (op_r == OP_DIV_I && stage_r == STAGE_LAST) begin
            op_nxt    = OP_X_S;
            state_nxt = ST_ISSUE;
          end else if (op_r == OP_Y_I) begin
            op_nxt    = OP_SI;
            stage_nxt = stage_r + 2'd1;
            state_nxt = ST_ISSUE;
          end else if (op_r == OP_X_I) begin
            state_nxt = ST_DONE;
          end else begin
            op_nxt    = op_t'(4'(op_r) + 4'd1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SI;
      stage_r     <= STAGE_FIRST;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      xs_r        <= '0;
      xi_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      stage_r     <= stage_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_ch.load_initial) begin
        xs_r <= in_ch.initial_s;
        xi_r <= in_ch.initial_i;
      end else if (wb && op_r == OP_X_S) begin
        xs_r <= add_res;
      end else if (wb && op_r == OP_X_I) begin
        xi_r <= add_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      time_r  <= in_ch.time_value;
      ys_r    <= xs_r;
      yi_r    <= xi_r;
      sum_s_r <= '0;
      sum_i_r <= '0;
    end else if (wb) begin
      unique case (op_r)
        OP_SI: begin
          t_r  <= mul_rsp.product;
          d0_r <= '0;
          d1_r <= '0;
        end
        OP_H0: h0_r <= mul_rsp.product;
        OP_H1: h1_r <= mul_rsp.product;
        OP_ST_0S, OP_ST_1S, OP_ST_2S: d0_r <= add_res;
        OP_ST_0I, OP_ST_1I, OP_ST_2I: d1_r <= add_res;
        OP_DIV_S: sum_s_r <= add_res;
        OP_DIV_I: sum_i_r <= add_res;
        OP_Y_S:   ys_r    <= add_res;
        OP_Y_I:   yi_r    <= add_res;
        default: ;
      endcase
    end
    if (out_load) begin
      out_time_r <= time_r;
      out_s_r    <= xs_r;
      out_i_r    <= xi_r;
      out_sat_r  <= sat_r;
    end
  end

endmodule

>>> src/rk4_reaction_ode_stepper_unit.sv
`timescale 1ns / 1ps

// Fourth-order Runge-Kutta stepper for a two-species, three-reaction network in saturating
// Q31.32 fixed point. A load item sets the state and is returned through the output register;
// a step item makes 44 passes through the shared 64-bit multiplier (each built from four
// 32-by-32 partial products and two sign fixes) and eight passes through the iterative
// divide-by-three unit. The input is not ready while an item is in flight, but a finished
// result waits in an output register so the next item may be taken before it is read.
// Configuration writes are always ready and must only be issued while the block is idle.
module rk4_reaction_ode_stepper_unit (
  input  logic        clk,
  input  logic        rst_n,
  rk4s_in_if.sink     in_ch,
  rk4s_out_if.source  out_ch,
  rk4s_cfg_if.sink    cfg_ch
);

  localparam rk4s_pkg::cfg_idx_t CFG_INFECTION = 3'd0;
  localparam rk4s_pkg::cfg_idx_t CFG_RECOVERY  = 3'd1;
  localparam rk4s_pkg::cfg_idx_t CFG_INFLOW    = 3'd2;
  localparam rk4s_pkg::cfg_idx_t CFG_STEP      = 3'd3;
  localparam rk4s_pkg::cfg_idx_t CFG_STOICH    = 3'd4;

  rk4s_pkg::cfg_t     cfg_r;
  rk4s_pkg::mul_req_t mul_req;
  rk4s_pkg::mul_rsp_t mul_rsp;
  rk4s_pkg::div_req_t div_req;
  rk4s_pkg::div_rsp_t div_rsp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        CFG_INFECTION: cfg_r.infection_coef <= cfg_ch.wdata;
        CFG_RECOVERY:  cfg_r.recovery_rate  <= cfg_ch.wdata;
        CFG_INFLOW:    cfg_r.inflow_rate    <= cfg_ch.wdata;
        CFG_STEP:      cfg_r.step_size      <= cfg_ch.wdata[rk4s_pkg::DT_W-1:0];
        CFG_STOICH:    cfg_r.stoich_packed  <= cfg_ch.wdata[rk4s_pkg::STO_W-1:0];
        default: ;
      endcase
    end
  end

  rk4s_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  rk4s_div3 u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rk4s_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mul_req (mul_req),
    .mul_rsp (mul_rsp),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rk4s_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INFECTION, REG_RECOVERY, REG_INFLOW, REG_STEP, REG_STOICH,
    REG_SPARE_5, REG_SPARE_6, REG_SPARE_7
  } reg_sel_e;

  typedef enum int unsigned {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_e;

  typedef struct packed {
    q_t   grid;
    q_t   sus;
    q_t   inf;
    logic sat;
  } row_t;

  localparam q_t          Q_ONE      = 64'sh0000_0001_0000_0000;
  localparam logic [63:0] DT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIR_STOICH = 64'h01F01F;
  localparam int          LONG_HOLD  = 3000;
  localparam int          IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;

  rk4s_in_if  in_bus ();
  rk4s_out_if out_bus ();
  rk4s_cfg_if cfg_bus ();

  rk4_reaction_ode_stepper_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  q_t          coef_m, rec_m, infl_m;
  logic [62:0] dt_m;
  logic [23:0] sto_m;
  q_t          sus_m, inf_m;
  bit          sat_hit;

  row_t        pending_rows[$];
  row_t        want;
  int unsigned err_count, rows_checked, sat_rows, loads_sent, steps_sent, reg_writes;
  int unsigned burst_left, holds_done, idle_cycles;
  bit          hold_req;
  rx_mode_e    rx_mode;
  int unsigned rx_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic q_t q_sum(q_t a, q_t b);
    q_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_hit = 1'b1;
      s = a[63] ? Q_MIN : Q_MAX;
    end
    return s;
  endfunction

  function automatic q_t q_prod(q_t a, q_t b);
    logic [127:0] wide;
    logic [32:0]  top;
    wide = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    top = wide[127:95];
    if (top != '0 && top != '1) begin
      sat_hit = 1'b1;
      return wide[127] ? Q_MIN : Q_MAX;
    end
    return wide[95:32];
  endfunction

  function automatic q_t q_div(q_t x, int unsigned d);
    logic [63:0] mag, quo;
    mag = x[63] ? -x : x;
    quo = mag / d;
    return x[63] ? -quo : quo;
  endfunction

  function automatic q_t sto_entry(int r, int sp);
    logic [3:0] nib;
    nib = sto_m[4*(2*r+sp) +: 4];
    return {{28{nib[3]}}, nib, 32'h0};
  endfunction

  function automatic void reaction_slope(input q_t s_v, input q_t i_v,
                                         output q_t d_s, output q_t d_i);
    q_t h [3];
    q_t d [2];
    h[0] = q_prod(q_prod(coef_m, s_v), i_v);
    h[1] = q_prod(rec_m, i_v);
    h[2] = infl_m;
    d[0] = '0;
    d[1] = '0;
    for (int r = 0; r < 3; r++)
      for (int sp = 0; sp < 2; sp++)
        d[sp] = q_sum(d[sp], q_prod(sto_entry(r, sp), h[r]));
    d_s = d[0];
    d_i = d[1];
  endfunction

  function automatic q_t blend_slopes(q_t k1, q_t k2, q_t k3, q_t k4);
    q_t a;
    a = q_sum(q_div(k1, 6), q_div(k2, 3));
    a = q_sum(a, q_div(k3, 3));
    return q_sum(a, q_div(k4, 6));
  endfunction

  function automatic row_t predict_row(logic load, q_t s_ld, q_t i_ld, q_t grid);
    row_t r;
    q_t   x0s, x0i, dt, half;
    q_t   k1s, k1i, k2s, k2i, k3s, k3i, k4s, k4i;
    sat_hit = 1'b0;
    x0s = sus_m;
    x0i = inf_m;
    dt = {1'b0, dt_m};
    half = dt >> 1;
    if (load) begin
      sus_m = s_ld;
      inf_m = i_ld;
    end else begin
      reaction_slope(x0s, x0i, k1s, k1i);
      reaction_slope(q_sum(x0s, q_prod(k1s, half)), q_sum(x0i, q_prod(k1i, half)), k2s, k2i);
      reaction_slope(q_sum(x0s, q_prod(k2s, half)), q_sum(x0i, q_prod(k2i, half)), k3s, k3i);
      reaction_slope(q_sum(x0s, q_prod(k3s, dt)), q_sum(x0i, q_prod(k3i, dt)), k4s, k4i);
      sus_m = q_sum(x0s, q_prod(blend_slopes(k1s, k2s, k3s, k4s), dt));
      inf_m = q_sum(x0i, q_prod(blend_slopes(k1i, k2i, k3i, k4i), dt));
    end
    r.grid = grid;
    r.sus  = sus_m;
    r.inf  = inf_m;
    r.sat  = sat_hit;
    return r;
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return $urandom_range(0, 1) ? q_t'(1) : -q_t'(1);
      4, 5: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(reg_sel_e idx, logic [63:0] val);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wdata     <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_INFECTION: coef_m = val;
      REG_RECOVERY:  rec_m  = val;
      REG_INFLOW:    infl_m = val;
      REG_STEP:      dt_m   = val[62:0];
      REG_STOICH:    sto_m  = val[23:0];
      default: ;
    endcase
    reg_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(q_t coef, q_t rec, q_t infl, logic [63:0] dt_w,
                            logic [63:0] sto_w);
    write_reg(REG_INFECTION, coef);
    write_reg(REG_RECOVERY, rec);
    write_reg(REG_INFLOW, infl);
    write_reg(REG_STEP, dt_w);
    write_reg(REG_STOICH, sto_w);
  endtask

  task automatic in_pause(int unsigned n);
    in_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(logic load, q_t s_ld, q_t i_ld, q_t grid);
    in_bus.valid        <= 1'b1;
    in_bus.load_initial <= load;
    in_bus.initial_s    <= s_ld;
    in_bus.initial_i    <= i_ld;
    in_bus.time_value   <= grid;
    do @(posedge clk); while (!in_bus.ready);
    pending_rows.push_back(predict_row(load, s_ld, i_ld, grid));
    if (load) loads_sent++;
    else steps_sent++;
  endtask

  task automatic paced_send(logic load, q_t s_ld, q_t i_ld, q_t grid);
    send_item(load, s_ld, i_ld, grid);
    if (burst_left == 0) begin
      in_pause(($urandom_range(0, 5) == 0) ? $urandom_range(1, 700) : $urandom_range(1, 4));
      burst_left = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_rows();
    in_pause(1);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(1'b0, '0, '0, '0);
    send_item(1'b1, Q_MAX, Q_MIN, Q_MIN);
    send_item(1'b0, '0, '0, Q_MAX);
    send_item(1'b1, Q_MIN, Q_MAX, '0);
    drain_rows();
  endtask

  task automatic test_directed_corners();
    set_config(Q_MAX, Q_MAX, Q_MAX, DT_MAX, 64'h777777);
    send_item(1'b1, Q_MAX, Q_MAX, Q_ONE);
    send_item(1'b0, '0, '0, Q_ONE);
    drain_rows();
    set_config(Q_MIN, Q_MIN, Q_MIN, DT_MAX, 64'h888888);
    send_item(1'b1, Q_MIN, Q_MIN, '0);
    send_item(1'b0, '0, '0, Q_ONE);
    send_item(1'b0, '0, '0, 2 * Q_ONE);
    drain_rows();
    set_config(64'd1288490, 64'd429496730, 64'h8000_0000, 64'h4000_0000, SIR_STOICH);
    send_item(1'b1, 1000 * Q_ONE, 10 * Q_ONE, '0);
    send_item(1'b0, '0, '0, 64'h4000_0000);
    send_item(1'b0, '0, '0, 64'h8000_0000);
    drain_rows();
    write_reg(REG_STEP, '0);
    send_item(1'b0, '0, '0, 64'hC000_0000);
    drain_rows();
    write_reg(REG_STEP, 64'h8000_0000_4000_0000);
    write_reg(REG_STOICH, 64'hFFFF_FFFF_FF01_F01F);
    send_item(1'b0, Q_MAX, Q_MAX, Q_ONE);
    send_item(1'b0, Q_MIN, Q_MIN, Q_ONE + 64'h4000_0000);
    drain_rows();
    set_config(-q_t'(1), -Q_ONE, -q_t'(1), 64'd1, 64'hA5C3E9);
    send_item(1'b1, -q_t'(1), q_t'(1), -Q_ONE);
    send_item(1'b0, '0, '0, '0);
    drain_rows();
  endtask

  task automatic test_ignored_index();
    write_reg(REG_SPARE_5, {$urandom, $urandom});
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    send_item(1'b1, 500 * Q_ONE, 3 * Q_ONE, '0);
    send_item(1'b0, '0, '0, Q_ONE);
    drain_rows();
  endtask

  task automatic test_sir_runs();
    q_t          grid, dt;
    int unsigned steps;
    for (int phase = 0; phase < 12; phase++) begin
      set_config(q_t'($urandom_range(1, 32'h0020_0000)), q_t'($urandom_range(0, 32'h8000_0000)),
                 q_t'($urandom), {31'h0, 1'($urandom_range(0, 1)), $urandom},
                 ($urandom_range(0, 3) == 0) ? 64'($urandom) : SIR_STOICH);
      dt = {1'b0, dt_m};
      for (int run = 0; run < 3; run++) begin
        grid = q_t'($urandom);
        paced_send(1'b1, {32'($urandom_range(0, 4000)), $urandom},
                   {32'($urandom_range(0, 200)), $urandom}, grid);
        steps = $urandom_range(5, 15);
        repeat (steps) begin
          grid = grid + dt;
          paced_send(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, grid);
        end
      end
      drain_rows();
    end
  endtask

  task automatic test_backpressure();
    set_config(64'd1288490, 64'd429496730, 64'h8000_0000, Q_ONE, SIR_STOICH);
    hold_req = 1'b1;
    send_item(1'b1, 2000 * Q_ONE, 50 * Q_ONE, '0);
    for (int n = 1; n <= 5; n++) send_item(1'b0, '0, '0, n * Q_ONE);
    drain_rows();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 8; phase++) begin
      set_config(rand_q(), rand_q(), rand_q(),
                 $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 32'h4_0000)),
                 {$urandom, $urandom});
      repeat (30) paced_send($urandom_range(0, 4) == 0, rand_q(), rand_q(), {$urandom, $urandom});
      drain_rows();
    end
  endtask

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(64, 600);
        end
        rx_left--;
        case (rx_mode)
          RX_FREE:   out_bus.ready <= 1'b1;
          RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_bus.ready <= ($urandom_range(0, 7) == 0);
          default:   out_bus.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (pending_rows.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, time_out %h s_out %h", $time,
                   out_bus.time_out, out_bus.s_out);
        end else begin
          want = pending_rows.pop_front();
          rows_checked++;
          if (want.sat) sat_rows++;
          if (out_bus.time_out !== want.grid) begin
            err_count++;
            $display("%0t: time_out expected %h actual %h", $time, want.grid, out_bus.time_out);
          end
          if (out_bus.s_out !== want.sus) begin
            err_count++;
            $display("%0t: s_out expected %h actual %h", $time, want.sus, out_bus.s_out);
          end
          if (out_bus.i_out !== want.inf) begin
            err_count++;
            $display("%0t: i_out expected %h actual %h", $time, want.inf, out_bus.i_out);
          end
          if (out_bus.saturated !== want.sat) begin
            err_count++;
            $display("%0t: saturated expected %b actual %b", $time, want.sat,
                     out_bus.saturated);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("rk4_reaction_ode_stepper_unit: mismatch");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.load_initial <= 1'b0;
    in_bus.initial_s    <= '0;
    in_bus.initial_i    <= '0;
    in_bus.time_value   <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.reg_index   <= REG_INFECTION;
    cfg_bus.wdata       <= '0;
    coef_m = '0;
    rec_m  = '0;
    infl_m = '0;
    dt_m   = '0;
    sto_m  = '0;
    sus_m  = '0;
    inf_m  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_corners();
    test_ignored_index();
    test_sir_runs();
    test_backpressure();
    test_random_mix();
    repeat (600) @(posedge clk);
    $display("Checked %0d results from %0d loads and %0d steps across %0d register writes.",
             rows_checked, loads_sent, steps_sent, reg_writes);
    $display("%0d results flagged saturation; %0d long output hold-offs were applied.",
             sat_rows, holds_done);
    if (err_count == 0)
      $display("rk4_reaction_ode_stepper_unit: match");
    else
      $display("rk4_reaction_ode_stepper_unit: mismatch");
    $finish;
  end

endmodule
